### rtl/dpfq_pkg.sv
// Shared types and codes for the double-ended priority FIFO queue.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package dpfq_pkg;

    localparam int AMOUNT_W = 20;
    localparam int ID_W     = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_ARRIVE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OLDEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RICHEST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_SERVED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [AMOUNT_W-1:0] amount;
    } entry_t;

    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

### rtl/fifo_and_priority_dual_queue_top.sv
// Channel        Dir  tdata                     tuser
// s_axis         in   [19:0] amount (pad 24)    [1:0] kind
// m_axis         out  [31:0] served_id          [1:0] status
//
// Arrival and kind 3 complete in the idle state with no result; an empty or full response
// goes through the done state to m_axis. Serve-oldest frees the head slot; serve-richest first
// scans all N occupied slots (one slot read a cycle). Both then skip the served slots at the
// head. A second result behind one waiting on m_axis stalls s_axis.
// s_axis_tready is high only while the sequencer is idle; a result waiting on m_axis
// does not block the next transaction. Reset is asynchronous and needs no clearing pass.
// Depends on dpfq_pkg, dpfq_ram, dpfq_ctrl.
`timescale 1ns / 1ps

module fifo_and_priority_dual_queue_top #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] amount, [23:20] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] served_id
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int SLOT_W = $clog2(CAPACITY);

    logic               res_valid;
    logic               res_ready;
    dpfq_pkg::result_t  res;
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    dpfq_pkg::entry_t   wr_data;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    dpfq_pkg::entry_t   rd_data;

    logic               out_valid_reg;
    dpfq_pkg::result_t  out_data_reg;

    dpfq_ctrl #(
        .CAPACITY (CAPACITY),
        .SLOT_W   (SLOT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_amount (s_axis_tdata[dpfq_pkg::AMOUNT_W-1:0]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    dpfq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (SLOT_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg.id;
    assign m_axis_tuser  = out_data_reg.status;

endmodule

### rtl/dpfq_ram.sv
// Slot store: one write port, one registered read port.
// Depends on dpfq_pkg for the entry type.
`timescale 1ns / 1ps

module dpfq_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  dpfq_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output dpfq_pkg::entry_t    rd_data
);

    dpfq_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/dpfq_ctrl.sv
// Sequencer and shared compare unit: arrivals, serves, richest scan, oldest skip.
// Depends on dpfq_pkg; drives the slot store in dpfq_ram.
`timescale 1ns / 1ps

module dpfq_ctrl #(
    parameter int CAPACITY = 64,
    parameter int SLOT_W   = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dpfq_pkg::KIND_W-1:0]         in_kind,
    input  logic [dpfq_pkg::AMOUNT_W-1:0]       in_amount,
    output logic                                res_valid,
    input  logic                                res_ready,
    output dpfq_pkg::result_t                   res,
    output logic                                wr_en,
    output logic [SLOT_W-1:0]                   wr_addr,
    output dpfq_pkg::entry_t                    wr_data,
    output logic                                rd_en,
    output logic [SLOT_W-1:0]                   rd_addr,
    input  dpfq_pkg::entry_t                    rd_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
    localparam logic [dpfq_pkg::ID_W-1:0] CAP_ID = dpfq_pkg::ID_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    logic [dpfq_pkg::ID_W-1:0]       next_id_reg, next_id_next;
    logic [dpfq_pkg::ID_W-1:0]       oldest_id_reg, oldest_id_next;
    logic [SLOT_W-1:0]               next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0]               oldest_slot_reg, oldest_slot_next;
    logic [CNT_W-1:0]                scan_left_reg, scan_left_next;
    logic [SLOT_W-1:0]               scan_slot_reg, scan_slot_next;
    logic [dpfq_pkg::ID_W-1:0]       scan_id_reg, scan_id_next;
    logic                            pend_reg, pend_next;
    logic [dpfq_pkg::ID_W-1:0]       pend_id_reg, pend_id_next;
    logic [SLOT_W-1:0]               pend_slot_reg, pend_slot_next;
    logic                            best_found_reg, best_found_next;
    logic [dpfq_pkg::AMOUNT_W-1:0]   best_amt_reg, best_amt_next;
    logic [dpfq_pkg::ID_W-1:0]       best_id_reg, best_id_next;
    logic [SLOT_W-1:0]               best_slot_reg, best_slot_next;
    dpfq_pkg::result_t               res_reg, res_next;

    logic [dpfq_pkg::ID_W-1:0]       span;
    logic                            accept;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    assign span      = next_id_reg - oldest_id_reg;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next       = state_reg;
        next_id_next     = next_id_reg;
        oldest_id_next   = oldest_id_reg;
        next_slot_next   = next_slot_reg;
        oldest_slot_next = oldest_slot_reg;
        scan_left_next   = scan_left_reg;
        scan_slot_next   = scan_slot_reg;
        scan_id_next     = scan_id_reg;
        pend_next        = 1'b0;
        pend_id_next     = pend_id_reg;
        pend_slot_next   = pend_slot_reg;
        best_found_next  = best_found_reg;
        best_amt_next    = best_amt_reg;
        best_id_next     = best_id_reg;
        best_slot_next   = best_slot_reg;
        res_next         = res_reg;
        wr_en            = 1'b0;
        wr_addr          = next_slot_reg;
        wr_data          = '0;
        rd_en            = 1'b0;
        rd_addr          = oldest_slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        dpfq_pkg::KIND_ARRIVE:
                        begin
                            if (span >= CAP_ID)
                            begin
                                res_next   = '{id: '0, status: dpfq_pkg::ST_FULL};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = next_slot_reg;
                                wr_data        = '{valid: 1'b1, amount: in_amount};
                                next_id_next   = next_id_reg + 1'b1;
                                next_slot_next = slot_inc(next_slot_reg);
                            end
                        end
                        dpfq_pkg::KIND_OLDEST:
                        begin
                            if (span == '0)
                            begin
                                res_next   = '{id: '0, status: dpfq_pkg::ST_EMPTY};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = oldest_slot_reg;
                                res_next   = '{id: oldest_id_reg, status: dpfq_pkg::ST_SERVED};
                                state_next = S_SKIP_RD;
                            end
                        end
                        dpfq_pkg::KIND_RICHEST:
                        begin
                            if (span == '0)
                            begin
                                res_next   = '{id: '0, status: dpfq_pkg::ST_EMPTY};
                                state_next = S_DONE;
                            end
                            else
                            begin
                                scan_left_next  = span[CNT_W-1:0];
                                scan_slot_next  = oldest_slot_reg;
                                scan_id_next    = oldest_id_reg;
                                best_found_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_left_reg != '0)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_slot_reg;
                    pend_next      = 1'b1;
                    pend_id_next   = scan_id_reg;
                    pend_slot_next = scan_slot_reg;
                    scan_id_next   = scan_id_reg + 1'b1;
                    scan_slot_next = slot_inc(scan_slot_reg);
                    scan_left_next = scan_left_reg - 1'b1;
                end
                if (pend_reg && rd_data.valid
                    && (!best_found_reg || rd_data.amount > best_amt_reg))
                begin
                    best_found_next = 1'b1;
                    best_amt_next   = rd_data.amount;
                    best_id_next    = pend_id_reg;
                    best_slot_next  = pend_slot_reg;
                end
                if (scan_left_reg == '0 && !pend_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = best_slot_reg;
                    res_next   = '{id: best_id_reg, status: dpfq_pkg::ST_SERVED};
                    state_next = S_SKIP_RD;
                end
            end
            S_SKIP_RD:
            begin
                if (oldest_id_reg == next_id_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = oldest_slot_reg;
                    state_next = S_SKIP_CHK;
                end
            end
            S_SKIP_CHK:
            begin
                if (rd_data.valid)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    oldest_id_next   = oldest_id_reg + 1'b1;
                    oldest_slot_next = slot_inc(oldest_slot_reg);
                    state_next       = S_SKIP_RD;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            next_id_reg     <= dpfq_pkg::ID_W'(1);
            oldest_id_reg   <= dpfq_pkg::ID_W'(1);
            next_slot_reg   <= SLOT_W'(1 % CAPACITY);
            oldest_slot_reg <= SLOT_W'(1 % CAPACITY);
            scan_left_reg   <= '0;
            scan_slot_reg   <= '0;
            scan_id_reg     <= '0;
            pend_reg        <= 1'b0;
            pend_id_reg     <= '0;
            pend_slot_reg   <= '0;
            best_found_reg  <= 1'b0;
            best_amt_reg    <= '0;
            best_id_reg     <= '0;
            best_slot_reg   <= '0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            next_id_reg     <= next_id_next;
            oldest_id_reg   <= oldest_id_next;
            next_slot_reg   <= next_slot_next;
            oldest_slot_reg <= oldest_slot_next;
            scan_left_reg   <= scan_left_next;
            scan_slot_reg   <= scan_slot_next;
            scan_id_reg     <= scan_id_next;
            pend_reg        <= pend_next;
            pend_id_reg     <= pend_id_next;
            pend_slot_reg   <= pend_slot_next;
            best_found_reg  <= best_found_next;
            best_amt_reg    <= best_amt_next;
            best_id_reg     <= best_id_next;
            best_slot_reg   <= best_slot_next;
            res_reg         <= res_next;
        end
    end

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        span <= CAP_ID)
        else $error("occupancy exceeds capacity");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && wr_addr == rd_addr))
        else $error("read and write hit the same slot");

    a_scan_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && scan_left_reg == '0 && !pend_reg) |-> best_found_reg)
        else $error("richest scan ended without a candidate");

    a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_kind != dpfq_pkg::KIND_ARRIVE && in_kind != dpfq_pkg::KIND_OLDEST
         && in_kind != dpfq_pkg::KIND_RICHEST) |=> state_reg == S_IDLE && $stable(span))
        else $error("unused kind changed state");

endmodule
